[rtl/assert_macros.svh]
// Assertion helpers used by radar_measurement_jacobian; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/rmj_pkg.sv]
package rmj_pkg;

    localparam int FIELD_W      = 32;
    localparam int WIDE_W       = 64;
    localparam int RATE_DEN_W   = 96;
    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STAGES  = 32;
    localparam int PROD_STAGES  = 2;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_STAGES   = DIV_STEPS + 1;

    localparam logic [FIELD_W-1:0] MIN_RANGE_SQ_RESET = 32'd429497;

    typedef struct packed {
        logic [FIELD_W-1:0] mx;
        logic [FIELD_W-1:0] my;
        logic [WIDE_W-1:0]  s;
        logic [WIDE_W-1:0]  cmag;
    } front_t;

    typedef struct packed {
        logic px_neg;
        logic py_neg;
        logic cneg;
        logic too_close;
    } flags_t;

    typedef struct packed {
        logic [FIELD_W-1:0]    mx;
        logic [FIELD_W-1:0]    my;
        logic [FIELD_W-1:0]    r;
        logic [WIDE_W-1:0]     s;
        logic [RATE_DEN_W-1:0] sr;
        logic [RATE_DEN_W-1:0] mxc;
        logic [RATE_DEN_W-1:0] myc;
    } prod_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] range_by_px;
        logic signed [FIELD_W-1:0] range_by_py;
        logic signed [FIELD_W-1:0] bearing_by_px;
        logic signed [FIELD_W-1:0] bearing_by_py;
        logic signed [FIELD_W-1:0] rate_by_px;
        logic signed [FIELD_W-1:0] rate_by_py;
        logic                      too_close;
    } res_t;

endpackage

[rtl/radar_measurement_jacobian.sv]
// Radar measurement Jacobian: takes one tracked state (pos_x, pos_y, vel_x, vel_y, signed
// fixed point with FRAC_BITS fraction bits) per request and returns the six nonzero
// Jacobian entries, each saturated to 32 bits, with too_close set and all entries zero
// when px^2 + py^2 is zero or below min_range_squared (written on the cfg port; the user
// must write it only while the block is idle, the block itself does not enforce this).
// The block takes one request every cycle while in_ready is high. Its pipeline is made
// of the 3 front stages, the 32-stage square root, the 2 product stages and the 33-stage
// long dividers that follow it, and a result is loaded into the output register at its
// end. A stalled output is backed by a one-entry skid buffer, so the pipeline holds only
// once both the output register and the skid buffer are full.
`include "assert_macros.svh"
module radar_measurement_jacobian #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  pos_x,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  pos_y,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  vel_x,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  vel_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rmj_pkg::FIELD_W-1:0]  range_by_px,
    output logic signed [rmj_pkg::FIELD_W-1:0]  range_by_py,
    output logic signed [rmj_pkg::FIELD_W-1:0]  bearing_by_px,
    output logic signed [rmj_pkg::FIELD_W-1:0]  bearing_by_py,
    output logic signed [rmj_pkg::FIELD_W-1:0]  rate_by_px,
    output logic signed [rmj_pkg::FIELD_W-1:0]  rate_by_py,
    output logic                                too_close,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rmj_pkg::FIELD_W-1:0]         cfg_data
);
    import rmj_pkg::*;

    localparam int RNG_NUM_W  = FIELD_W + FRAC_BITS;
    localparam int BRG_NUM_W  = FIELD_W + 2 * FRAC_BITS;
    localparam int RATE_NUM_W = RATE_DEN_W + FRAC_BITS;
    localparam int FLAG_DEPTH = SQRT_STAGES + PROD_STAGES + DIV_STAGES;
    localparam int LAT        = FRONT_STAGES + FLAG_DEPTH;

    localparam logic [FIELD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] SAT_NEG = 32'h8000_0000;

    logic               en;
    logic [FIELD_W-1:0] min_range_sq_reg;
    logic               v_reg    [LAT];
    flags_t             flag_reg [FLAG_DEPTH];

    front_t             front, sq_side;
    flags_t             front_flags, fl;
    logic [FIELD_W-1:0] root;
    prod_t              prod;

    logic [RNG_NUM_W-1:0]  rng_num_x, rng_num_y;
    logic [BRG_NUM_W-1:0]  brg_num_x, brg_num_y;
    logic [RATE_NUM_W-1:0] rate_num_x, rate_num_y;
    logic [DIV_STEPS-1:0]  q_rx, q_ry, q_bx, q_by, q_tx, q_ty;
    logic                  o_rx, o_ry, o_bx, o_by, o_tx, o_ty;

    res_t               pipe_res;
    res_t               out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               out_free, push;

    function automatic logic [FIELD_W-1:0] sat_field(
        input logic [DIV_STEPS-1:0] q,
        input logic                 ovf,
        input logic                 neg
    );
        logic big;
        begin
            big = ovf || q[DIV_STEPS-1];
            if (neg)
                sat_field = big ? SAT_NEG : (~q + 32'd1);
            else
                sat_field = big ? SAT_POS : q;
        end
    endfunction

    assign en        = !skid_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_range_sq_reg <= MIN_RANGE_SQ_RESET;
        else if (cfg_valid)
            min_range_sq_reg <= cfg_data;
    end

    rmj_front u_front (
        .clk          (clk),
        .en           (en),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .min_range_sq (min_range_sq_reg),
        .front        (front),
        .flags        (front_flags)
    );

    rmj_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .side_in  (front),
        .side_out (sq_side),
        .root     (root)
    );

    rmj_prod u_prod (
        .clk     (clk),
        .en      (en),
        .side_in (sq_side),
        .root    (root),
        .prod    (prod)
    );

    assign rng_num_x  = RNG_NUM_W'(prod.mx) << FRAC_BITS;
    assign rng_num_y  = RNG_NUM_W'(prod.my) << FRAC_BITS;
    assign brg_num_x  = BRG_NUM_W'(prod.mx) << (2 * FRAC_BITS);
    assign brg_num_y  = BRG_NUM_W'(prod.my) << (2 * FRAC_BITS);
    assign rate_num_x = RATE_NUM_W'(prod.mxc) << FRAC_BITS;
    assign rate_num_y = RATE_NUM_W'(prod.myc) << FRAC_BITS;

    rmj_div #(.NUM_W(RNG_NUM_W), .DEN_W(FIELD_W)) u_div_rx (
        .clk (clk), .en (en), .num (rng_num_x), .den (prod.r), .quot (q_rx), .over (o_rx)
    );
    rmj_div #(.NUM_W(RNG_NUM_W), .DEN_W(FIELD_W)) u_div_ry (
        .clk (clk), .en (en), .num (rng_num_y), .den (prod.r), .quot (q_ry), .over (o_ry)
    );
    rmj_div #(.NUM_W(BRG_NUM_W), .DEN_W(WIDE_W)) u_div_bx (
        .clk (clk), .en (en), .num (brg_num_x), .den (prod.s), .quot (q_bx), .over (o_bx)
    );
    rmj_div #(.NUM_W(BRG_NUM_W), .DEN_W(WIDE_W)) u_div_by (
        .clk (clk), .en (en), .num (brg_num_y), .den (prod.s), .quot (q_by), .over (o_by)
    );
    rmj_div #(.NUM_W(RATE_NUM_W), .DEN_W(RATE_DEN_W)) u_div_tx (
        .clk (clk), .en (en), .num (rate_num_y), .den (prod.sr), .quot (q_tx), .over (o_tx)
    );
    rmj_div #(.NUM_W(RATE_NUM_W), .DEN_W(RATE_DEN_W)) u_div_ty (
        .clk (clk), .en (en), .num (rate_num_x), .den (prod.sr), .quot (q_ty), .over (o_ty)
    );

    // valid bits and sign flags run alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag_reg[0] <= front_flags;
            for (int i = 1; i < FLAG_DEPTH; i++)
                flag_reg[i] <= flag_reg[i-1];
        end
    end

    always_comb
    begin
        fl = flag_reg[FLAG_DEPTH-1];
        pipe_res.range_by_px   = sat_field(q_rx, o_rx, fl.px_neg);
        pipe_res.range_by_py   = sat_field(q_ry, o_ry, fl.py_neg);
        pipe_res.bearing_by_px = sat_field(q_by, o_by, !fl.py_neg);
        pipe_res.bearing_by_py = sat_field(q_bx, o_bx, fl.px_neg);
        pipe_res.rate_by_px    = sat_field(q_tx, o_tx, fl.py_neg != fl.cneg);
        pipe_res.rate_by_py    = sat_field(q_ty, o_ty, fl.px_neg == fl.cneg);
        pipe_res.too_close     = 1'b0;
        if (fl.too_close)
        begin
            pipe_res           = '0;
            pipe_res.too_close = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign push     = en && v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= pipe_res;
        end
        else if (push)
        begin
            // hold the finished request until the output drains
            skid_reg <= pipe_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign range_by_px   = out_reg.range_by_px;
    assign range_by_py   = out_reg.range_by_py;
    assign bearing_by_px = out_reg.bearing_by_px;
    assign bearing_by_py = out_reg.bearing_by_py;
    assign rate_by_px    = out_reg.rate_by_px;
    assign rate_by_py    = out_reg.rate_by_py;
    assign too_close     = out_reg.too_close;

    `ASSERT_ALWAYS(a_skid_needs_out, clk, rst_n, !skid_valid_reg || out_valid_reg, "skid entry without output entry")
    `ASSERT_ALWAYS(a_close_zero, clk, rst_n, !(out_valid && too_close) || (range_by_px == '0 && range_by_py == '0 && bearing_by_px == '0 && bearing_by_py == '0 && rate_by_px == '0 && rate_by_py == '0), "too close result with nonzero entries")
    `ASSERT_NEXT(a_skid_fill, clk, rst_n, push && out_valid_reg && !out_ready, skid_valid_reg, "blocked result not caught in skid buffer")
    `ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_valid_reg && out_ready, !skid_valid_reg && out_valid_reg, "skid buffer failed to drain")

endmodule

[rtl/rmj_front.sv]
module rmj_front (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  pos_x,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  pos_y,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  vel_x,
    input  logic signed [rmj_pkg::FIELD_W-1:0]  vel_y,
    input  logic [rmj_pkg::FIELD_W-1:0]         min_range_sq,
    output rmj_pkg::front_t                     front,
    output rmj_pkg::flags_t                     flags
);
    import rmj_pkg::*;

    // stage 1: magnitudes and signs
    logic signed [FIELD_W-1:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [FIELD_W-1:0]        mx1_reg, my1_reg;
    logic                      pxn1_reg, pyn1_reg;
    // stage 2: products
    logic [WIDE_W-1:0]         sqx_reg, sqy_reg;
    logic signed [WIDE_W-1:0]  a_reg, b_reg;
    logic [FIELD_W-1:0]        mx2_reg, my2_reg;
    logic                      pxn2_reg, pyn2_reg;
    // stage 3
    front_t                    front_reg;
    flags_t                    flags_reg;

    logic [FIELD_W-1:0]        mx_next, my_next;
    logic [WIDE_W-1:0]         sqx_next, sqy_next;
    logic signed [WIDE_W-1:0]  a_next, b_next;
    logic [WIDE_W-1:0]         s_next;
    logic                      cneg_next;
    front_t                    front_next;
    flags_t                    flags_next;

    always_comb
    begin
        mx_next = pos_x[FIELD_W-1] ? (~pos_x + 32'd1) : pos_x;
        my_next = pos_y[FIELD_W-1] ? (~pos_y + 32'd1) : pos_y;
    end

    always_comb
    begin
        sqx_next = mx1_reg * mx1_reg;
        sqy_next = my1_reg * my1_reg;
        a_next   = vx_reg * py_reg;
        b_next   = vy_reg * px_reg;
    end

    always_comb
    begin
        s_next    = sqx_reg + sqy_reg;
        cneg_next = a_reg < b_reg;
        front_next.mx   = mx2_reg;
        front_next.my   = my2_reg;
        front_next.s    = s_next;
        front_next.cmag = cneg_next ? WIDE_W'(b_reg - a_reg) : WIDE_W'(a_reg - b_reg);
        flags_next.px_neg    = pxn2_reg;
        flags_next.py_neg    = pyn2_reg;
        flags_next.cneg      = cneg_next;
        // a zero position has no Jacobian, whatever the threshold
        flags_next.too_close = (s_next == '0) || (s_next < {32'd0, min_range_sq});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            vx_reg    <= vel_x;
            vy_reg    <= vel_y;
            mx1_reg   <= mx_next;
            my1_reg   <= my_next;
            pxn1_reg  <= pos_x[FIELD_W-1];
            pyn1_reg  <= pos_y[FIELD_W-1];
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            mx2_reg   <= mx1_reg;
            my2_reg   <= my1_reg;
            pxn2_reg  <= pxn1_reg;
            pyn2_reg  <= pyn1_reg;
            front_reg <= front_next;
            flags_reg <= flags_next;
        end
    end

    assign front = front_reg;
    assign flags = flags_reg;

endmodule

[rtl/rmj_isqrt.sv]
module rmj_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  rmj_pkg::front_t               side_in,
    output rmj_pkg::front_t               side_out,
    output logic [rmj_pkg::FIELD_W-1:0]   root
);
    import rmj_pkg::*;

    logic [WIDE_W-1:0] x_reg   [SQRT_STAGES-1];
    logic [WIDE_W-1:0] res_reg [SQRT_STAGES];
    front_t            side_reg[SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        localparam logic [WIDE_W-1:0] BIT = 64'd1 << (WIDE_W - 2 - 2 * i);
        logic [WIDE_W-1:0] x_cur, res_cur, trial;
        front_t            side_cur;
        logic              take;

        if (i == 0)
        begin : g_head
            assign x_cur    = side_in.s;
            assign res_cur  = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_body
            assign x_cur    = x_reg[i-1];
            assign res_cur  = res_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        always_comb
        begin
            trial = res_cur + BIT;
            take  = x_cur >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[i]  <= take ? ((res_cur >> 1) + BIT) : (res_cur >> 1);
                side_reg[i] <= side_cur;
            end
        end

        if (i < SQRT_STAGES - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= take ? (x_cur - trial) : x_cur;
                end
            end
        end
    end

    assign root     = res_reg[SQRT_STAGES-1][FIELD_W-1:0];
    assign side_out = side_reg[SQRT_STAGES-1];

endmodule

[rtl/rmj_prod.sv]
module rmj_prod (
    input  logic                          clk,
    input  logic                          en,
    input  rmj_pkg::front_t               side_in,
    input  logic [rmj_pkg::FIELD_W-1:0]   root,
    output rmj_pkg::prod_t                prod
);
    import rmj_pkg::*;

    logic [WIDE_W-1:0]  srl_reg, srh_reg, xl_reg, xh_reg, yl_reg, yh_reg;
    logic [FIELD_W-1:0] mx_reg, my_reg, r_reg;
    logic [WIDE_W-1:0]  s_reg;
    prod_t              prod_reg;
    prod_t              prod_next;

    always_comb
    begin
        prod_next.mx  = mx_reg;
        prod_next.my  = my_reg;
        prod_next.r   = r_reg;
        prod_next.s   = s_reg;
        prod_next.sr  = RATE_DEN_W'(srl_reg) + (RATE_DEN_W'(srh_reg) << FIELD_W);
        prod_next.mxc = RATE_DEN_W'(xl_reg) + (RATE_DEN_W'(xh_reg) << FIELD_W);
        prod_next.myc = RATE_DEN_W'(yl_reg) + (RATE_DEN_W'(yh_reg) << FIELD_W);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // split the 64 by 32 products into 32 by 32 halves
            srl_reg  <= side_in.s[FIELD_W-1:0] * root;
            srh_reg  <= side_in.s[WIDE_W-1:FIELD_W] * root;
            xl_reg   <= side_in.cmag[FIELD_W-1:0] * side_in.mx;
            xh_reg   <= side_in.cmag[WIDE_W-1:FIELD_W] * side_in.mx;
            yl_reg   <= side_in.cmag[FIELD_W-1:0] * side_in.my;
            yh_reg   <= side_in.cmag[WIDE_W-1:FIELD_W] * side_in.my;
            mx_reg   <= side_in.mx;
            my_reg   <= side_in.my;
            r_reg    <= root;
            s_reg    <= side_in.s;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/rmj_div.sv]
module rmj_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [NUM_W-1:0]                num,
    input  logic [DEN_W-1:0]                den,
    output logic [rmj_pkg::DIV_STEPS-1:0]   quot,
    output logic                            over
);
    import rmj_pkg::*;

    localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic [DEN_W-1:0]     rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0]     den_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] low_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] quot_reg [DIV_STEPS+1];
    logic                 over_reg [DIV_STEPS+1];

    logic                 head_over;
    logic [DEN_W-1:0]     head_rem;

    // quotient of 2^32 or more saturates anyway, so flag it up front
    always_comb
    begin
        head_over = CMP_W'(num >> DIV_STEPS) >= CMP_W'(den);
        head_rem  = head_over ? '0 : DEN_W'(num >> DIV_STEPS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= head_rem;
            den_reg[0]  <= den;
            low_reg[0]  <= num[DIV_STEPS-1:0];
            quot_reg[0] <= '0;
            over_reg[0] <= head_over;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           take;

        always_comb
        begin
            trial = {rem_reg[k-1], low_reg[k-1][DIV_STEPS-1]};
            take  = trial >= {1'b0, den_reg[k-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quot_reg[k] <= {quot_reg[k-1][DIV_STEPS-2:0], take};
                over_reg[k] <= over_reg[k-1];
            end
        end

        if (k < DIV_STEPS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? DEN_W'(trial - {1'b0, den_reg[k-1]})
                                       : trial[DEN_W-1:0];
                    den_reg[k] <= den_reg[k-1];
                    low_reg[k] <= {low_reg[k-1][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign quot = quot_reg[DIV_STEPS];
    assign over = over_reg[DIV_STEPS];

endmodule

[sim/radar_measurement_jacobian_test.sv]
`timescale 1ns / 100ps

module radar_measurement_jacobian_test;

    import rmj_pkg::*;

    localparam int FRAC     = 16;
    localparam int SETTLE   = 90;
    localparam int WDOG_MAX = 20000;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } track_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] range_by_px, range_by_py, bearing_by_px, bearing_by_py;
    logic signed [31:0] rate_by_px, rate_by_py;
    logic too_close;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;

    track_t pending_tracks[$];
    res_t   jacobians_due[$];
    logic [31:0] min_range_sq = MIN_RANGE_SQ_RESET;
    int errors = 0;
    int results_seen = 0;
    int close_seen = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit no_idle = 1'b0;
    logic in_ready_seen = 1'b0;

    always #2 clk = ~clk;

    radar_measurement_jacobian dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .range_by_px(range_by_px), .range_by_py(range_by_py),
        .bearing_by_px(bearing_by_px), .bearing_by_py(bearing_by_py),
        .rate_by_px(rate_by_px), .rate_by_py(rate_by_py),
        .too_close(too_close),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res, bit_v;
        res = '0;
        bit_v = 64'h4000_0000_0000_0000;
        while (bit_v > x)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (x >= res + bit_v)
            begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
                res = res >> 1;
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // quotient clamped to 2^32 so the sign step can saturate it
    function automatic logic [32:0] quot_sat(logic [127:0] n, logic [127:0] d);
        logic [127:0] q;
        q = n / d;
        return (q >= 128'h1_0000_0000) ? 33'h1_0000_0000 : q[32:0];
    endfunction

    function automatic logic [31:0] signed_sat(logic [32:0] mag, bit neg);
        if (neg)
            return (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        return (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic res_t jacobian_of(track_t t, logic [31:0] thr);
        res_t o;
        logic [32:0] mx, my;
        logic [63:0] s, r, cmag;
        logic signed [64:0] a, b, c;
        logic [127:0] sr;
        bit cneg;
        o = '0;
        mx = t.px[31] ? 33'd0 - {1'b1, t.px} : {1'b0, t.px};
        my = t.py[31] ? 33'd0 - {1'b1, t.py} : {1'b0, t.py};
        s = 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
        if (s == 0 || s < 64'(thr))
        begin
            o.too_close = 1'b1;
            return o;
        end
        r = root_floor(s);
        sr = 128'(s) * 128'(r);
        a = 65'(t.vx) * 65'(t.py);
        b = 65'(t.vy) * 65'(t.px);
        c = a - b;
        cneg = c < 0;
        cmag = cneg ? 64'(-c) : 64'(c);
        o.range_by_px   = signed_sat(quot_sat(128'(mx) << FRAC, 128'(r)), t.px[31]);
        o.range_by_py   = signed_sat(quot_sat(128'(my) << FRAC, 128'(r)), t.py[31]);
        o.bearing_by_px = signed_sat(quot_sat(128'(my) << (2*FRAC), 128'(s)), !t.py[31]);
        o.bearing_by_py = signed_sat(quot_sat(128'(mx) << (2*FRAC), 128'(s)), t.px[31]);
        o.rate_by_px = signed_sat(quot_sat((128'(my) * 128'(cmag)) << FRAC, sr),
                                  t.py[31] != cneg);
        o.rate_by_py = signed_sat(quot_sat((128'(mx) * 128'(cmag)) << FRAC, sr),
                                  t.px[31] == cneg);
        o.too_close = 1'b0;
        return o;
    endfunction

    function automatic int pick_gap();
        int u;
        if (no_idle)
            return 0;
        u = $urandom_range(99);
        if (u < 65)
            return 0;
        if (u < 95)
            return $urandom_range(3, 1);
        return $urandom_range(200, 20);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom;
        // spread magnitudes from tiny up to full scale
        case ($urandom_range(3))
            0: v = v >>> $urandom_range(31, 20);
            1: v = v >>> $urandom_range(19, 8);
            2: v = v >>> $urandom_range(7, 1);
            default: ;
        endcase
        return v;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    task automatic add_track(logic [31:0] px, logic [31:0] py,
                             logic [31:0] vx, logic [31:0] vy);
        track_t t;
        t.px = px; t.py = py; t.vx = vx; t.vy = vy;
        pending_tracks.push_back(t);
    endtask

    task automatic write_threshold(logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        min_range_sq = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= $urandom;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_tracks.size() != 0 || in_valid || jacobians_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request driver and output back-pressure
    always @(negedge clk)
    begin
        if (in_valid && !(in_ready_seen))
            ;
        else if (in_gap > 0)
        begin
            in_gap   <= in_gap - 1;
            in_valid <= 1'b0;
        end
        else if (pending_tracks.size() != 0)
        begin
            track_t t;
            t = pending_tracks.pop_front();
            pos_x <= t.px; pos_y <= t.py; vel_x <= t.vx; vel_y <= t.vy;
            in_valid <= 1'b1;
            in_gap   <= pick_gap();
        end
        else
            in_valid <= 1'b0;

        if (out_gap > 0)
        begin
            out_gap   <= out_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!no_idle && $urandom_range(9) == 0)
                out_gap <= pick_gap();
        end
    end

    // acceptance, prediction, result checking and the watchdog
    always @(posedge clk)
    begin
        track_t t;
        res_t want;
        bit moved;
        moved = 1'b0;
        in_ready_seen <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            t.px = pos_x; t.py = pos_y; t.vx = vel_x; t.vy = vel_y;
            jacobians_due.push_back(jacobian_of(t, min_range_sq));
            moved = 1'b1;
        end
        if (rst_n && cfg_valid && cfg_ready)
            moved = 1'b1;
        if (rst_n && out_valid && out_ready)
        begin
            moved = 1'b1;
            results_seen++;
            if (jacobians_due.size() == 0)
            begin
                report("unexpected result", range_by_px, 32'd0);
            end
            else
            begin
                want = jacobians_due.pop_front();
                if (too_close) close_seen++;
                if (range_by_px !== want.range_by_px)
                    report("range_by_px", range_by_px, want.range_by_px);
                if (range_by_py !== want.range_by_py)
                    report("range_by_py", range_by_py, want.range_by_py);
                if (bearing_by_px !== want.bearing_by_px)
                    report("bearing_by_px", bearing_by_px, want.bearing_by_px);
                if (bearing_by_py !== want.bearing_by_py)
                    report("bearing_by_py", bearing_by_py, want.bearing_by_py);
                if (rate_by_px !== want.rate_by_px)
                    report("rate_by_px", rate_by_px, want.rate_by_px);
                if (rate_by_py !== want.rate_by_py)
                    report("rate_by_py", rate_by_py, want.rate_by_py);
                if (too_close !== want.too_close)
                    report("too_close", 32'(too_close), 32'(want.too_close));
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("watchdog: no progress for %0d cycles", WDOG_MAX);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] thresholds[5];
        thresholds[0] = MIN_RANGE_SQ_RESET;
        thresholds[1] = 32'd0;
        thresholds[2] = 32'hFFFF_FFFF;
        thresholds[3] = $urandom;
        thresholds[4] = $urandom_range(2000000, 1);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(thresholds[ph]);
            no_idle = (ph == 2);
            if (ph == 0)
            begin
                // zero position, extremes, axes and the threshold boundary
                add_track(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
                add_track(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
                add_track(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
                add_track(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
                add_track(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0);
                add_track(32'h1, 32'h0, 32'hFFFF_FFFF, 32'h1);
                add_track(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                add_track(32'd655, 32'd0, 32'h0001_0000, 32'h0);
                add_track(32'd656, 32'd0, 32'h0001_0000, 32'h0);
                add_track(32'hFFFF_FD70, 32'd0, 32'h0, 32'hFFFF_0000);
                add_track(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
                add_track(32'h0000_0100, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                add_track(32'h7FFF_FFFF, 32'h1, 32'h8000_0000, 32'h8000_0000);
                add_track(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                add_track(32'h0003_0000, 32'hFFFC_0000, 32'h0002_8000, 32'hFFFF_C000);
            end
            for (int i = 0; i < 390; i++)
                add_track(rand_coord(), rand_coord(), $urandom, rand_coord());
            drain();
        end

        $display("checked %0d jacobians (%0d too close) over 5 threshold settings",
                 results_seen, close_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rmj_pkg.sv
rtl/rmj_front.sv
rtl/rmj_isqrt.sv
rtl/rmj_prod.sv
rtl/rmj_div.sv
rtl/radar_measurement_jacobian.sv
sim/radar_measurement_jacobian_test.sv
